### rtl/urs_pkg.sv
// Shared types and constants for the uniform range sampler.
package urs_pkg;

    localparam int WORD_W = 32;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [1:0] KIND_COIN  = 2'd0;
    localparam logic [1:0] KIND_FIXED = 2'd1;
    localparam logic [1:0] KIND_RANGE = 2'd2;

    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_END   = 2'd1;
    localparam logic [1:0] CFG_COIN  = 2'd2;

    localparam int COIN_BIT = 15;

    typedef struct packed {
        logic [1:0]        kind;
        logic [WORD_W-1:0] word;
    } t_req;

endpackage

### rtl/urs_front.sv
// Front end: takes raw words and tags each request with how it is to be mapped.
module urs_front (
    input  logic                  start,
    input  logic [31:0]           i_random_word,
    input  logic                  i_coin_mode,
    input  logic                  i_span_zero,
    input  logic                  i_q_full,
    output logic                  busy,
    output logic                  o_push,
    output urs_pkg::t_req         o_req
);
    import urs_pkg::*;

    assign busy   = i_q_full;
    assign o_push = start && !i_q_full;

    always_comb begin
        o_req.word = i_random_word;
        if (i_coin_mode) begin
            o_req.kind = KIND_COIN;
        end else if (i_span_zero) begin
            o_req.kind = KIND_FIXED;
        end else begin
            o_req.kind = KIND_RANGE;
        end
    end

endmodule

### rtl/urs_queue.sv
// Short request queue between the front end and the reduction pipeline.
module urs_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  urs_pkg::t_req         i_req,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output urs_pkg::t_req         o_req
);
    import urs_pkg::*;

    t_req              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

### rtl/urs_back.sv
// Back end: pipelined restoring remainder, rejection test and offset add.
module urs_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  urs_pkg::t_req         i_q_req,
    input  logic [31:0]           i_range_start,
    input  logic [31:0]           i_span,
    input  logic [31:0]           i_negspan,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [31:0]           o_sample
);
    import urs_pkg::*;

    // one quotient bit per stage
    logic              r_sv    [WORD_W];
    logic [1:0]        r_skind [WORD_W];
    logic [WORD_W-1:0] r_sword [WORD_W];
    logic [WORD_W-1:0] r_srem  [WORD_W];
    logic [WORD_W-1:0] n_srem  [WORD_W];

    logic              r_ov;
    logic [WORD_W-1:0] r_osample;
    logic              n_ov;
    logic [WORD_W-1:0] n_osample;

    logic [WORD_W-1:0] l_word;
    logic [WORD_W-1:0] l_rem;
    logic [WORD_W-1:0] l_diff;

    assign o_pop = i_q_valid;

    always_comb begin
        logic [WORD_W:0]   t;
        logic [WORD_W-1:0] prev;
        logic              bitv;
        for (int k = 0; k < WORD_W; k++) begin
            if (k == 0) begin
                prev = '0;
                bitv = i_q_req.word[WORD_W-1];
            end else begin
                prev = r_srem[k-1];
                bitv = r_sword[k-1][WORD_W-1-k];
            end
            t = {prev, bitv};
            if (t >= {1'b0, i_span}) begin
                n_srem[k] = WORD_W'(t - {1'b0, i_span});
            end else begin
                n_srem[k] = t[WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WORD_W; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else begin
            r_sv[0] <= i_q_valid;
            for (int k = 1; k < WORD_W; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_skind[0] <= i_q_req.kind;
        r_sword[0] <= i_q_req.word;
        for (int k = 1; k < WORD_W; k++) begin
            r_skind[k] <= r_skind[k-1];
            r_sword[k] <= r_sword[k-1];
        end
        for (int k = 0; k < WORD_W; k++) begin
            r_srem[k] <= n_srem[k];
        end
    end

    // word - rem is the quotient times span; reject when one more span passes 2^32
    assign l_word = r_sword[WORD_W-1];
    assign l_rem  = r_srem[WORD_W-1];
    assign l_diff = l_word - l_rem;

    always_comb begin
        n_ov      = 1'b0;
        n_osample = i_range_start;
        unique case (r_skind[WORD_W-1])
            KIND_COIN: begin
                n_ov      = r_sv[WORD_W-1];
                n_osample = {{(WORD_W-1){1'b0}}, l_word[COIN_BIT]};
            end
            KIND_FIXED: begin
                n_ov      = r_sv[WORD_W-1];
                n_osample = i_range_start;
            end
            KIND_RANGE: begin
                n_ov      = r_sv[WORD_W-1] && (l_diff <= i_negspan);
                n_osample = i_range_start + l_rem;
            end
            default: begin
                n_ov      = 1'b0;
                n_osample = i_range_start;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_osample <= n_osample;
    end

    assign o_valid  = r_ov;
    assign o_sample = r_osample;

endmodule

### rtl/uniform_range_sampler.sv
// Top level of the uniform range sampler: config registers and block wiring.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+----------------------------
//  request   | in        | start, busy                | i_random_word
//  result    | out       | o_sample_valid (strobe)    | o_sample
//  config    | in        | i_cfg_valid, o_cfg_ready   | i_cfg_index, i_cfg_data
//
//  One request is taken every cycle; busy only rises if the queue fills.
//  Requests pass the queue, the 32-stage restoring remainder pipeline
//  (one quotient bit per stage) and the output registers. Rejected words give
//  no strobe. Reset (synchronous, low) clears the config registers to zero but
//  sets the span-zero flag, and empties the pipeline. Results cannot be stalled.
module uniform_range_sampler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_random_word,
    output logic        o_sample_valid,
    output logic [31:0] o_sample,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import urs_pkg::*;

    logic [31:0] r_range_start;
    logic [31:0] r_range_end;
    logic        r_coin_mode;
    logic [31:0] r_span;
    logic [31:0] r_negspan;
    logic        r_span_zero;

    logic [31:0] n_range_start;
    logic [31:0] n_range_end;
    logic        n_coin_mode;
    logic [31:0] n_span;

    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_valid;
    t_req        front_req;
    t_req        q_req;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_range_start = r_range_start;
        n_range_end   = r_range_end;
        n_coin_mode   = r_coin_mode;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START: n_range_start = i_cfg_data;
                CFG_END:   n_range_end   = i_cfg_data;
                CFG_COIN:  n_coin_mode   = i_cfg_data[0];
                default:   n_coin_mode   = r_coin_mode;
            endcase
        end
        n_span = n_range_end - n_range_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_start <= '0;
            r_range_end   <= '0;
            r_coin_mode   <= 1'b0;
            r_span        <= '0;
            r_negspan     <= '0;
            r_span_zero   <= 1'b1;
        end else begin
            r_range_start <= n_range_start;
            r_range_end   <= n_range_end;
            r_coin_mode   <= n_coin_mode;
            r_span        <= n_span;
            r_negspan     <= 32'd0 - n_span;
            r_span_zero   <= (n_span == 32'd0);
        end
    end

    urs_front u_front (
        .start         (start),
        .i_random_word (i_random_word),
        .i_coin_mode   (r_coin_mode),
        .i_span_zero   (r_span_zero),
        .i_q_full      (q_full),
        .busy          (busy),
        .o_push        (q_push),
        .o_req         (front_req)
    );

    urs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_req   (front_req),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_req   (q_req)
    );

    urs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_req       (q_req),
        .i_range_start (r_range_start),
        .i_span        (r_span),
        .i_negspan     (r_negspan),
        .o_pop         (q_pop),
        .o_valid       (o_sample_valid),
        .o_sample      (o_sample)
    );

endmodule

### sim/tb_uniform_range_sampler.sv
// Self-checking testbench for uniform_range_sampler: directed and random words, range and coin.
`timescale 1ns / 1ps

module tb_uniform_range_sampler;
    import urs_pkg::*;

    localparam logic [1:0] CFG_UNUSED   = 2'd3;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         PHASE_ITEMS  = 48;

    class sample_tracker;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic              coin;
        logic [WORD_W-1:0] expected_samples[$];
        int                checked;
        int                dropped;

        function new();
            lo = '0;
            hi = '0;
            coin = 1'b0;
            checked = 0;
            dropped = 0;
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [WORD_W-1:0] data);
            case (idx)
                CFG_START: lo = data;
                CFG_END:   hi = data;
                CFG_COIN:  coin = data[0];
                default: ;
            endcase
        endfunction

        // largest word kept for the current span; above it the word is dropped
        function logic [WORD_W-1:0] accept_limit();
            logic [WORD_W-1:0] span;
            logic [WORD_W:0]   excess;
            span = hi - lo;
            if (span == '0)
                return '1;
            if (span <= 32'h8000_0000) begin
                excess = 33'h1_0000_0000 % {1'b0, span};
                return 32'hFFFF_FFFF - excess[WORD_W-1:0];
            end
            return span - 1;
        endfunction

        function void note_request(input logic [WORD_W-1:0] word);
            logic [WORD_W-1:0] span;
            span = hi - lo;
            if (coin) begin
                expected_samples.push_back({31'b0, word[COIN_BIT]});
            end else if (span == '0) begin
                expected_samples.push_back(lo);
            end else if (word > accept_limit()) begin
                dropped++;
            end else begin
                expected_samples.push_back(lo + word % span);
            end
        endfunction

        function bit check_result(input logic [WORD_W-1:0] got, output string msg);
            logic [WORD_W-1:0] want;
            msg = "";
            if (expected_samples.size() == 0) begin
                msg = $sformatf("sample %08h with no request pending", got);
                return 1'b0;
            end
            want = expected_samples.pop_front();
            checked++;
            if (got !== want) begin
                msg = $sformatf("sample %08h, expected %08h", got, want);
                return 1'b0;
            end
            return 1'b1;
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [WORD_W-1:0] i_random_word;
    logic              o_sample_valid;
    logic [WORD_W-1:0] o_sample;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [WORD_W-1:0] i_cfg_data;

    sample_tracker tracker;
    int            mismatches = 0;
    int            idle_pct = 0;
    int            stall_cycles = 0;
    string         mismatch_msg;
    logic [WORD_W-1:0] base;

    uniform_range_sampler i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_random_word  (i_random_word),
        .o_sample_valid (o_sample_valid),
        .o_sample       (o_sample),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && o_sample_valid) begin
            if (!tracker.check_result(o_sample, mismatch_msg))
                report_mismatch(mismatch_msg);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_sample_valid || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no activity for %0d cycles", STALL_LIMIT);
            $display("uniform_range_sampler verification failed");
            $finish;
        end
    end

    task automatic send_word(input logic [WORD_W-1:0] w);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_random_word <= w;
        @(negedge i_clk);
        while (busy)
            @(negedge i_clk);
        @(posedge i_clk);
        tracker.note_request(w);
    endtask

    // dropped words may still be in flight after the last result, so wait out the pipe
    task automatic drain();
        start <= 1'b0;
        while (tracker.expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        while (!o_cfg_ready)
            @(negedge i_clk);
        @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    task automatic configure(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                             input logic [WORD_W-1:0] coin_word, input bit poke_unused);
        drain();
        write_reg(CFG_START, lo);
        write_reg(CFG_END, hi);
        write_reg(CFG_COIN, coin_word);
        if (poke_unused)
            write_reg(CFG_UNUSED, $urandom());
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] lim;
        lim = tracker.accept_limit();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return lim - 1 + $urandom_range(2);
            default: return $urandom();
        endcase
    endfunction

    task automatic run_phase(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                             input logic [WORD_W-1:0] coin_word);
        configure(lo, hi, coin_word, 1'b0);
        repeat (PHASE_ITEMS) send_word(pick_word());
    endtask

    initial begin
        tracker = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        i_random_word = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_START;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset state: zero span, every word maps to start
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);

        // span 3: limit one below all-ones, unused index must not disturb anything
        configure(32'd0, 32'd3, 32'd0, 1'b1);
        send_word(32'd0);
        send_word(32'd1);
        send_word(32'd2);
        send_word(32'hFFFF_FFFE);
        send_word(32'hFFFF_FFFF);

        // wrapped range, coin write with only upper bits set
        configure(32'hFFFF_FFF0, 32'h0000_0010, 32'hFFFF_FFFE, 1'b0);
        send_word(32'h0000_0000);
        send_word(32'h0000_001F);
        send_word(32'h0000_0020);

        // maximal span
        configure(32'h0000_0000, 32'hFFFF_FFFF, 32'd0, 1'b0);
        send_word(32'hFFFF_FFFE);
        send_word(32'hFFFF_FFFF);

        // span just above half a word
        configure(32'h0000_0000, 32'h8000_0001, 32'd0, 1'b0);
        send_word(32'h8000_0000);
        send_word(32'h8000_0001);

        configure(32'd0, 32'd0, 32'd1, 1'b0);
        send_word(32'h0000_8000);
        send_word(32'hFFFF_7FFF);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0000);

        idle_pct = 7;
        run_phase(32'd0, 32'd3, 32'd0);
        run_phase(32'h0000_0000, 32'hFFFF_FFFF, 32'd0);
        run_phase(32'h0000_0000, 32'h8000_0000, 32'd0);
        run_phase(32'h0000_000A, 32'h8000_000B, 32'hFFFF_FFFE);

        idle_pct = 77;
        run_phase(32'hFFFF_FFF0, 32'h0000_0010, 32'd0);
        run_phase($urandom(), $urandom(), 32'd0);
        run_phase($urandom(), $urandom(), 32'hFFFF_FFFF);

        idle_pct = 0;
        base = $urandom();
        run_phase(base, base, 32'd0);
        run_phase(32'hFFFF_FFFF, 32'h0000_0000, 32'd0);
        base = $urandom();
        run_phase(base, base + $urandom_range(2, 1000), 32'd0);

        drain();
        $display("checked %0d samples; %0d words fell above the acceptance limit",
                 tracker.checked, tracker.dropped);
        $display("spans covered: zero, one, small, wrapped, half word, maximal; coin on and off");
        if (mismatches == 0)
            $display("uniform_range_sampler verification clean");
        else
            $display("uniform_range_sampler verification failed");
        $finish;
    end

endmodule
